// ===== design/teh_pkg.sv =====
package teh_pkg;

	localparam int ExpW = 32;
	localparam int IdW  = 16;
	localparam int TmoW = 24;
	localparam int SerW = 32;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_CANCEL = 2'd1,
		REQ_SWEEP  = 2'd2,
		REQ_NOP    = 2'd3
	} req_op_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_EXPIRED   = 2'd3;

	typedef struct packed {
		logic [ExpW-1:0] expiry;
		logic [IdW-1:0]  conn;
		logic            deleted;
		logic [SerW-1:0] order;
	} entry_t;

	typedef struct packed {
		req_op_t         op;
		logic [IdW-1:0]  conn_id;
		logic [TmoW-1:0] timeout_ms;
		logic [ExpW-1:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [1:0]     status;
		logic [IdW-1:0] expired_id;
		logic           last;
	} rsp_t;

	// earlier expiry first, then earlier insertion
	function automatic logic sorts_before(entry_t a, entry_t b);
		logic r;
		if (a.expiry != b.expiry) r = a.expiry < b.expiry;
		else r = a.order < b.order;
		return r;
	endfunction

endpackage

// ===== design/teh_ram.sv =====
module teh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

// ===== design/teh_fifo.sv =====
module teh_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW:0] wr_q, rd_q;

	assign empty = wr_q == rd_q;
	assign full  = (wr_q[PW] != rd_q[PW]) && (wr_q[PW-1:0] == rd_q[PW-1:0]);
	assign rdata = slot_q[rd_q[PW-1:0]];

	always_ff @(posedge clk) begin
		if (push && !full) slot_q[wr_q[PW-1:0]] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + 1'b1;
			if (pop && !empty) rd_q <= rd_q + 1'b1;
		end
	end
endmodule

// ===== design/teh_front.sv =====
module teh_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [1:0]              req_type,
	input  logic [teh_pkg::IdW-1:0]  conn_id,
	input  logic [teh_pkg::TmoW-1:0] timeout_ms,
	input  logic [teh_pkg::ExpW-1:0] now_ms,
	output logic                    req_valid,
	output teh_pkg::req_t           req,
	input  logic                    req_pop
);
	import teh_pkg::*;

	req_t in_word;
	logic q_empty;

	always_comb begin
		in_word.conn_id    = conn_id;
		in_word.timeout_ms = timeout_ms;
		in_word.now_ms     = now_ms;
		unique case (req_type)
			2'd0: in_word.op = REQ_ADD;
			2'd1: in_word.op = REQ_CANCEL;
			2'd2: in_word.op = REQ_SWEEP;
			default: in_word.op = REQ_NOP;
		endcase
	end

	teh_fifo #(.WIDTH($bits(req_t)), .DEPTH(4)) u_req_q (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(in_word), .full(full),
		.pop(req_pop), .rdata(req), .empty(q_empty)
	);

	assign req_valid = !q_empty;
endmodule

// ===== design/teh_heap.sv =====
module teh_heap #(
	parameter int HEAP_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  teh_pkg::req_t                     req,
	output logic                              req_pop,
	output logic                              rsp_push,
	output teh_pkg::rsp_t                     rsp,
	input  logic                              rsp_full,
	output logic [$clog2(HEAP_DEPTH+1)-1:0]   count
);
	import teh_pkg::*;

	localparam int AW = $clog2(HEAP_DEPTH);
	localparam int CW = $clog2(HEAP_DEPTH+1);

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_UP     = 13'b0000000000010,
		S_UP_CMP = 13'b0000000000100,
		S_CAN_RD = 13'b0000000001000,
		S_CAN_CK = 13'b0000000010000,
		S_SW     = 13'b0000000100000,
		S_SW_CK  = 13'b0000001000000,
		S_POP    = 13'b0000010000000,
		S_DN     = 13'b0000100000000,
		S_DN_L   = 13'b0001000000000,
		S_DN_CMP = 13'b0010000000000,
		S_SW_END = 13'b0100000000000,
		S_FIN    = 13'b1000000000000
	} state_t;

	state_t state_q;
	req_t req_q;
	entry_t cur_q, lft_q, rdata, wdata;
	logic [AW-1:0] idx_q, raddr, waddr, idx_m1, parent;
	logic [CW-1:0] cnt_q, cnt_m1;
	logic [CW:0] left, right;
	logic [SerW-1:0] serial_q;
	logic found_q, rt_q, pend_q, we, re;
	logic [IdW-1:0] pend_id_q;
	logic [1:0] fin_st_q;
	logic [IdW-1:0] fin_id_q;
	logic hit, top_go, top_hold, child_rt;
	entry_t child;

	teh_ram #(.WIDTH($bits(entry_t)), .DEPTH(HEAP_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	assign count  = cnt_q;
	assign idx_m1 = idx_q - AW'(1);
	assign parent = idx_m1 >> 1;
	assign cnt_m1 = cnt_q - CW'(1);
	assign left   = (CW+1)'({idx_q, 1'b1});
	assign right  = left + (CW+1)'(1);
	assign hit    = !rdata.deleted && (rdata.conn == req_q.conn_id);
	assign top_go = (req_q.now_ms >= rdata.expiry) || rdata.deleted;
	// a newly expired id pushes out the one held back, which needs room
	assign top_hold = top_go && !rdata.deleted && pend_q && rsp_full;
	assign child_rt = rt_q && sorts_before(rdata, lft_q);
	assign child    = child_rt ? rdata : lft_q;

	always_comb begin
		req_pop  = 1'b0;
		rsp_push = 1'b0;
		rsp      = '{status: fin_st_q, expired_id: fin_id_q, last: 1'b1};
		we       = 1'b0;
		waddr    = idx_q;
		wdata    = cur_q;
		re       = 1'b0;
		raddr    = '0;
		unique case (state_q)
			S_IDLE: req_pop = req_valid;
			S_UP: begin
				if (idx_q == '0) we = 1'b1;
				else begin
					re    = 1'b1;
					raddr = parent;
				end
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (sorts_before(cur_q, rdata)) wdata = rdata;
			end
			S_CAN_RD: begin
				re    = 1'b1;
				raddr = idx_q;
			end
			S_CAN_CK: begin
				we    = hit;
				wdata = rdata;
				wdata.deleted = 1'b1;
			end
			S_SW: re = cnt_q != '0;
			S_SW_CK: begin
				if (top_go && !top_hold) begin
					if (!rdata.deleted && pend_q) begin
						rsp_push = 1'b1;
						rsp = '{status: ST_EXPIRED, expired_id: pend_id_q, last: 1'b0};
					end
					if (cnt_m1 != '0) begin
						re    = 1'b1;
						raddr = cnt_m1[AW-1:0];
					end
				end
			end
			S_POP: ;
			S_DN: begin
				if (left >= {1'b0, cnt_q}) we = 1'b1;
				else begin
					re    = 1'b1;
					raddr = left[AW-1:0];
				end
			end
			S_DN_L: begin
				if (right < {1'b0, cnt_q}) begin
					re    = 1'b1;
					raddr = right[AW-1:0];
				end
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (sorts_before(child, cur_q)) wdata = child;
			end
			S_SW_END: ;
			S_FIN: rsp_push = !rsp_full;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (req_valid) req_q <= req;
			S_POP: cur_q <= rdata;
			S_DN_L: lft_q <= rdata;
			default: ;
		endcase
		if (state_q == S_IDLE && req_valid) begin
			cur_q.expiry  <= req.now_ms + ExpW'(req.timeout_ms);
			cur_q.conn    <= req.conn_id;
			cur_q.deleted <= 1'b0;
			cur_q.order   <= serial_q;
		end
		if (state_q == S_SW_CK && top_go && !top_hold && !rdata.deleted) pend_id_q <= rdata.conn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			serial_q <= '0;
			idx_q    <= '0;
			found_q  <= 1'b0;
			pend_q   <= 1'b0;
			rt_q     <= 1'b0;
			fin_st_q <= ST_OK;
			fin_id_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						fin_st_q <= ST_OK;
						fin_id_q <= '0;
						found_q  <= 1'b0;
						pend_q   <= 1'b0;
						idx_q    <= '0;
						case (req.op)
							REQ_ADD: begin
								if (cnt_q == CW'(HEAP_DEPTH)) begin
									fin_st_q <= ST_FULL;
									state_q  <= S_FIN;
								end else begin
									idx_q    <= cnt_q[AW-1:0];
									cnt_q    <= cnt_q + CW'(1);
									serial_q <= serial_q + SerW'(1);
									state_q  <= S_UP;
								end
							end
							REQ_CANCEL: begin
								if (cnt_q == '0) begin
									fin_st_q <= ST_NOT_FOUND;
									state_q  <= S_FIN;
								end else state_q <= S_CAN_RD;
							end
							REQ_SWEEP: state_q <= S_SW;
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_UP: begin
					if (idx_q == '0) state_q <= S_FIN;
					else state_q <= S_UP_CMP;
				end
				S_UP_CMP: begin
					if (sorts_before(cur_q, rdata)) begin
						idx_q   <= parent;
						state_q <= S_UP;
					end else state_q <= S_FIN;
				end
				S_CAN_RD: state_q <= S_CAN_CK;
				S_CAN_CK: begin
					if (hit) found_q <= 1'b1;
					if (CW'(idx_q) == cnt_m1) begin
						fin_st_q <= (found_q || hit) ? ST_OK : ST_NOT_FOUND;
						state_q  <= S_FIN;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_CAN_RD;
					end
				end
				S_SW: begin
					if (cnt_q == '0) state_q <= S_SW_END;
					else state_q <= S_SW_CK;
				end
				S_SW_CK: begin
					if (!top_go) state_q <= S_SW_END;
					else if (!top_hold) begin
						if (!rdata.deleted) pend_q <= 1'b1;
						cnt_q <= cnt_m1;
						idx_q <= '0;
						if (cnt_m1 == '0) state_q <= S_SW;
						else state_q <= S_POP;
					end
				end
				S_POP: state_q <= S_DN;
				S_DN: begin
					if (left >= {1'b0, cnt_q}) state_q <= S_SW;
					else state_q <= S_DN_L;
				end
				S_DN_L: begin
					rt_q    <= right < {1'b0, cnt_q};
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (sorts_before(child, cur_q)) begin
						idx_q   <= child_rt ? right[AW-1:0] : left[AW-1:0];
						state_q <= S_DN;
					end else state_q <= S_SW;
				end
				S_SW_END: begin
					fin_st_q <= pend_q ? ST_EXPIRED : ST_OK;
					fin_id_q <= pend_q ? pend_id_q : '0;
					state_q  <= S_FIN;
				end
				S_FIN: if (!rsp_full) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== design/timer_expiry_heap.sv =====
// channel   direction  handshake            word
// request   in         push / full          req_type, conn_id, timeout_ms, now_ms
// result    out        pop / empty          status, expired_id, last
// add: starts at the new last slot and climbs toward the root, moving each later parent down a level
// cancel: reads every stored entry in turn and marks each live match as deleted
// sweep: while the top has expired or is deleted, pops it and sifts the last entry down from the root,
// then closes; the single read port of the entry memory sets the pace
// reset empties the heap and both queues at once, no clearing pass
// a full result queue stalls the sequencer; the 4-deep request queue keeps taking words until it is full
module timer_expiry_heap #(
	parameter int HEAP_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [15:0] conn_id,
	input  logic [23:0] timeout_ms,
	input  logic [31:0] now_ms,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [15:0] expired_id,
	output logic        last
);
	import teh_pkg::*;

	req_t req;
	rsp_t rsp, out_word;
	logic req_valid, req_pop, rsp_push, rsp_full;
	logic [$clog2(HEAP_DEPTH+1)-1:0] count;

	teh_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .conn_id(conn_id), .timeout_ms(timeout_ms), .now_ms(now_ms),
		.req_valid(req_valid), .req(req), .req_pop(req_pop)
	);

	teh_heap #(.HEAP_DEPTH(HEAP_DEPTH)) u_heap (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req(req), .req_pop(req_pop),
		.rsp_push(rsp_push), .rsp(rsp), .rsp_full(rsp_full), .count(count)
	);

	teh_fifo #(.WIDTH($bits(rsp_t)), .DEPTH(4)) u_rsp_q (
		.clk(clk), .arst_n(arst_n), .push(rsp_push), .wdata(rsp), .full(rsp_full),
		.pop(pop), .rdata(out_word), .empty(empty)
	);

	assign status     = out_word.status;
	assign expired_id = out_word.expired_id;
	assign last       = out_word.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= ($clog2(HEAP_DEPTH+1))'(HEAP_DEPTH))
		else $error("heap count past depth");

	a_no_lost_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		!(rsp_push && rsp_full))
		else $error("result pushed into full queue");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count != $past(count)) |->
			(count == $past(count) + 1'b1) || (count == $past(count) - 1'b1))
		else $error("heap count jumped");
endmodule

// ===== test/timer_expiry_heap_tb.sv =====
module timer_expiry_heap_tb;
	import teh_pkg::*;

	localparam int Depth = 64;
	localparam int CycleLimit = 2000000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  req_type;
	logic [15:0] conn_id;
	logic [23:0] timeout_ms;
	logic [31:0] now_ms;
	logic        empty;
	logic        pop;
	logic [1:0]  status;
	logic [15:0] expired_id;
	logic        last;

	int  fail_count;
	int  cycles;
	bit  calm;
	bit  hold_rx;
	logic [31:0] clock_ms;
	logic [15:0] recent_ids[$];

	task automatic report_mismatch(string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		fail_count++;
	endtask

	// software copy of the timer heap, predicts the result words
	class timer_scoreboard;
		logic [31:0] exp_q[$];
		logic [15:0] conn_q[$];
		bit          del_q[$];
		logic [31:0] ord_q[$];
		logic [31:0] serial;
		rsp_t        pending[$];

		function new();
			serial = 0;
		endfunction

		function bit earlier(int a, int b);
			if (exp_q[a] != exp_q[b]) return exp_q[a] < exp_q[b];
			return ord_q[a] < ord_q[b];
		endfunction

		function void swap(int a, int b);
			logic [31:0] e;
			logic [15:0] c;
			bit          d;
			logic [31:0] o;
			e = exp_q[a]; exp_q[a] = exp_q[b]; exp_q[b] = e;
			c = conn_q[a]; conn_q[a] = conn_q[b]; conn_q[b] = c;
			d = del_q[a]; del_q[a] = del_q[b]; del_q[b] = d;
			o = ord_q[a]; ord_q[a] = ord_q[b]; ord_q[b] = o;
		endfunction

		function void drop_top();
			int n;
			int i;
			int l;
			int best;
			n = exp_q.size() - 1;
			swap(0, n);
			void'(exp_q.pop_back()); void'(conn_q.pop_back());
			void'(del_q.pop_back()); void'(ord_q.pop_back());
			i = 0;
			forever begin
				l = 2 * i + 1;
				best = i;
				if (l < n && earlier(l, best)) best = l;
				if (l + 1 < n && earlier(l + 1, best)) best = l + 1;
				if (best == i) break;
				swap(i, best);
				i = best;
			end
		endfunction

		function void note(rsp_t r);
			pending.push_back(r);
		endfunction

		function void accept(req_op_t op, logic [15:0] id, logic [23:0] tmo, logic [31:0] now);
			int   i;
			int   p;
			int   n;
			bit   hit;
			rsp_t r;
			r = '0;
			case (op)
				REQ_ADD: begin
					if (exp_q.size() >= Depth) r.status = ST_FULL;
					else begin
						exp_q.push_back(now + 32'(tmo));
						conn_q.push_back(id);
						del_q.push_back(0);
						ord_q.push_back(serial);
						serial++;
						i = exp_q.size() - 1;
						while (i > 0) begin
							p = (i - 1) / 2;
							if (!earlier(i, p)) break;
							swap(i, p);
							i = p;
						end
						r.status = ST_OK;
					end
				end
				REQ_CANCEL: begin
					hit = 0;
					foreach (conn_q[k])
						if (!del_q[k] && conn_q[k] == id) begin
							del_q[k] = 1;
							hit = 1;
						end
					r.status = hit ? ST_OK : ST_NOT_FOUND;
				end
				REQ_SWEEP: begin
					n = 0;
					while (exp_q.size() > 0 && (now >= exp_q[0] || del_q[0])) begin
						r.status = ST_EXPIRED;
						r.expired_id = conn_q[0];
						hit = del_q[0];
						drop_top();
						if (!hit && n < Depth) begin
							note(r);
							n++;
						end
					end
					if (n > 0) begin
						pending[$].last = 1;
						return;
					end
					r = '0;
				end
				default: r.status = ST_OK;
			endcase
			r.last = 1;
			note(r);
		endfunction

		task check(rsp_t got);
			rsp_t w;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected word %p", got));
				return;
			end
			w = pending.pop_front();
			if (got.status !== w.status)
				report_mismatch($sformatf("status %0d want %0d", got.status, w.status));
			if (got.expired_id !== w.expired_id)
				report_mismatch($sformatf("expired_id %0h want %0h", got.expired_id, w.expired_id));
			if (got.last !== w.last)
				report_mismatch($sformatf("last %0d want %0d", got.last, w.last));
		endtask
	endclass

	timer_scoreboard timers;

	timer_expiry_heap #(.HEAP_DEPTH(Depth)) i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .conn_id(conn_id), .timeout_ms(timeout_ms), .now_ms(now_ms),
		.empty(empty), .pop(pop), .status(status), .expired_id(expired_id), .last(last)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout");
			$display("status: fail");
			$finish;
		end
	end

	// one word offered until it is taken
	task automatic send(req_op_t op, logic [15:0] id, logic [23:0] tmo, logic [31:0] now);
		push <= 1;
		req_type <= op;
		conn_id <= id;
		timeout_ms <= tmo;
		now_ms <= now;
		@(posedge clk);
		while (full) @(posedge clk);
		timers.accept(op, id, tmo, now);
		if (!calm && $urandom_range(0, 3) == 0) begin
			push <= 0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic send_random();
		int          pick;
		logic [15:0] id;
		pick = $urandom_range(0, 99);
		id = (recent_ids.size() > 0 && $urandom_range(0, 2) != 0) ?
			recent_ids[$urandom_range(0, recent_ids.size() - 1)] : 16'($urandom);
		clock_ms += $urandom_range(0, 400);
		if (pick < 50) begin
			recent_ids.push_back(id);
			if (recent_ids.size() > 20) void'(recent_ids.pop_front());
			send(REQ_ADD, id, (pick < 3) ? 24'($urandom) : 24'($urandom_range(0, 3000)),
				clock_ms);
		end else if (pick < 70)
			send(REQ_CANCEL, id, 24'($urandom), 32'($urandom));
		else if (pick < 97)
			send(REQ_SWEEP, 16'($urandom), 24'($urandom), clock_ms);
		else
			send(REQ_NOP, 16'($urandom), 24'($urandom), 32'($urandom));
	endtask

	// receiver: random pop bursts, or a long hold-off on request
	initial begin
		pop = 0;
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				pop <= 0;
				repeat (300) @(posedge clk);
				hold_rx = 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				pop <= 0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				pop <= 1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && pop && !empty)
			timers.check('{status: status, expired_id: expired_id, last: last});

	initial begin
		int wait_cycles;
		timers = new();
		fail_count = 0;
		cycles = 0;
		calm = 0;
		hold_rx = 0;
		clock_ms = 1000;
		push = 0;
		req_type = REQ_NOP;
		conn_id = 0;
		timeout_ms = 0;
		now_ms = 0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty heap cases, extremes, overflow of the expiry sum
		send(REQ_SWEEP, 16'h0, 24'h0, 32'hFFFF_FFFF);
		send(REQ_CANCEL, 16'hFFFF, 24'hFF_FFFF, 32'h0);
		send(REQ_NOP, 16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF);
		send(REQ_ADD, 16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF);
		send(REQ_ADD, 16'h0000, 24'h0, 32'h0);
		send(REQ_ADD, 16'h1234, 24'd5, 32'd100);
		send(REQ_ADD, 16'h5678, 24'd5, 32'd100);
		send(REQ_ADD, 16'h1234, 24'd0, 32'd10);
		send(REQ_CANCEL, 16'h1234, 24'h0, 32'h0);
		send(REQ_CANCEL, 16'h1234, 24'h0, 32'h0);
		send(REQ_SWEEP, 16'h0, 24'h0, 32'd104);
		send(REQ_SWEEP, 16'h0, 24'h0, 32'd105);
		send(REQ_SWEEP, 16'h0, 24'h0, 32'hFFFF_FFFF);
		// fill to the top while the receiver holds off, then refused adds
		hold_rx = 1;
		for (int k = 0; k < Depth + 2; k++)
			send(REQ_ADD, 16'(k), 24'(k % 7), 32'd5000);
		send(REQ_CANCEL, 16'd3, 24'h0, 32'h0);
		send(REQ_SWEEP, 16'h0, 24'h0, 32'd5003);
		send(REQ_SWEEP, 16'h0, 24'h0, 32'hFFFF_FFFF);

		for (int k = 0; k < 380; k++) begin
			if (k == 320) calm = 1;
			send_random();
		end
		send(REQ_SWEEP, 16'h0, 24'h0, 32'hFFFF_FFFF);
		push <= 0;

		wait_cycles = 0;
		while (timers.pending.size() > 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (2000) @(posedge clk);
		if (timers.pending.size() > 0)
			report_mismatch($sformatf("%0d words never came", timers.pending.size()));
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
design/teh_pkg.sv
design/teh_ram.sv
design/teh_fifo.sv
design/teh_front.sv
design/teh_heap.sv
design/timer_expiry_heap.sv
test/timer_expiry_heap_tb.sv
